// ===== rtl/opsm_pkg.sv =====
// Shared types and constants of the OFDM pilot and subcarrier mapper.
`default_nettype none

package opsm_pkg;

  // Fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int INDEX_W     = 10;
  localparam int FFT_POINTS  = 1024;
  localparam int BSTART_W    = 10;
  localparam int BWIDTH_W    = 11;
  localparam int PTOTAL_W    = 7;
  localparam int PSPACE_W    = 11;
  localparam int PFIRST_W    = 10;
  localparam int PILOT_POS_W = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic [PILOT_POS_W-1:0] PILOT_SAT  = 11'd2047;
  localparam logic [INDEX_W-1:0]     LAST_INDEX = INDEX_W'(FFT_POINTS - 1);

  // Register reset values
  localparam logic [BSTART_W-1:0]   RST_BAND_START    = 10'd128;
  localparam logic [BWIDTH_W-1:0]   RST_BAND_WIDTH    = 11'd768;
  localparam logic [PTOTAL_W-1:0]   RST_PILOT_TOTAL   = 7'd32;
  localparam logic [PSPACE_W-1:0]   RST_PILOT_SPACING = 11'd24;
  localparam logic [PFIRST_W-1:0]   RST_PILOT_FIRST   = 10'd0;
  localparam logic [SAMPLE_W-1:0]   RST_PILOT_REAL    = 16'd21299;
  localparam logic [SAMPLE_W-1:0]   RST_PILOT_IMAG    = 16'd0;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_START    = 3'd0,
    REG_BAND_WIDTH    = 3'd1,
    REG_PILOT_TOTAL   = 3'd2,
    REG_PILOT_SPACING = 3'd3,
    REG_PILOT_FIRST   = 3'd4,
    REG_PILOT_REAL    = 3'd5,
    REG_PILOT_IMAG    = 3'd6
  } reg_idx_t;

  // Request kinds carried on tuser
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EMIT = 1'b1
  } req_t;

  // Source of a pending subcarrier value
  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_PILOT = 2'd1,
    SRC_DATA  = 2'd2
  } src_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_PEND = 2'b10
  } state_t;

  typedef struct packed {
    logic [BSTART_W-1:0] band_start;
    logic [BWIDTH_W-1:0] band_width;
    logic [PTOTAL_W-1:0] pilot_total;
    logic [PSPACE_W-1:0] pilot_spacing;
    logic [PFIRST_W-1:0] pilot_first;
    logic [SAMPLE_W-1:0] pilot_real;
    logic [SAMPLE_W-1:0] pilot_imag;
  } cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // store one data symbol
    logic emit;   // classify next subcarrier, issue buffer read
    logic move;   // pending result into the output register
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ofdm_pilot_subcarrier_mapper_core.sv =====
// Top level of the OFDM pilot and subcarrier mapper: register file and wiring.
//
//  Channel  Direction  Content
//  in_      slave      load or emit request; tuser = kind, tdata = data symbol
//  out_     master     one subcarrier per emit; tlast on the final subcarrier
//  cfg_     write      band and pilot registers, index 0..6
//
//  A load request writes the symbol buffer; an emit request first classifies
//  the slot and reads the symbol buffer, then moves the value into the output
//  register, which is set from the buffer's registered read, once it is free.
//  in_tready drops only while an emit result is pending and stays low
//  while out_tready is low and the output register is full.
//  rst_n is synchronous; the buffer is not cleared and needs no sweep.
`default_nettype none

module ofdm_pilot_subcarrier_mapper_core
  import opsm_pkg::*;
#(
  parameter int BUFFER_DEPTH = 1024
)(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // sym_real, sym_imag
  input  wire logic                   in_tuser,   // req_type
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // carrier_real, carrier_imag,
                                                  // carrier_index, zero fill
  output logic                        out_tlast,  // end_of_symbol
  input  wire logic                   cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t                cfg_r;
  cmd_t                cmd;
  logic [SAMPLE_W-1:0] carrier_real, carrier_imag;
  logic [INDEX_W-1:0]  carrier_index;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_start    <= RST_BAND_START;
      cfg_r.band_width    <= RST_BAND_WIDTH;
      cfg_r.pilot_total   <= RST_PILOT_TOTAL;
      cfg_r.pilot_spacing <= RST_PILOT_SPACING;
      cfg_r.pilot_first   <= RST_PILOT_FIRST;
      cfg_r.pilot_real    <= RST_PILOT_REAL;
      cfg_r.pilot_imag    <= RST_PILOT_IMAG;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BAND_START:    cfg_r.band_start    <= cfg_wdata[BSTART_W-1:0];
        REG_BAND_WIDTH:    cfg_r.band_width    <= cfg_wdata[BWIDTH_W-1:0];
        REG_PILOT_TOTAL:   cfg_r.pilot_total   <= cfg_wdata[PTOTAL_W-1:0];
        REG_PILOT_SPACING: cfg_r.pilot_spacing <= cfg_wdata[PSPACE_W-1:0];
        REG_PILOT_FIRST:   cfg_r.pilot_first   <= cfg_wdata[PFIRST_W-1:0];
        REG_PILOT_REAL:    cfg_r.pilot_real    <= cfg_wdata[SAMPLE_W-1:0];
        REG_PILOT_IMAG:    cfg_r.pilot_imag    <= cfg_wdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  opsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  opsm_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg           (cfg_r),
    .sym_real      (in_tdata[SAMPLE_W-1:0]),
    .sym_imag      (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .carrier_real  (carrier_real),
    .carrier_imag  (carrier_imag),
    .carrier_index (carrier_index),
    .end_of_symbol (out_tlast)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {{(OUT_TDATA_W - 2*SAMPLE_W - INDEX_W){1'b0}},
                      carrier_index, carrier_imag, carrier_real};

endmodule

`default_nettype wire

// ===== rtl/opsm_ctrl.sv =====
// Controller state machine: request acceptance and output register valid.
`default_nettype none

module opsm_ctrl
  import opsm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tuser,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  // Accept only with no result pending
  assign in_tready = (state_r == ST_IDLE);
  assign take      = in_tvalid && in_tready;

  always_comb begin
    cmd.load = take && (req_t'(in_tuser) == REQ_LOAD);
    cmd.emit = take && (req_t'(in_tuser) == REQ_EMIT);
    cmd.move = (state_r == ST_PEND) && (!out_valid_r || out_tready);
  end

  // Advance state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.emit) state_nxt = ST_PEND;
      end
      ST_PEND: begin
        if (cmd.move) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold output valid until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_emit_pends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == ST_PEND))
    else $error("emit request did not leave a pending result");

  a_valid_from_move: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.move))
    else $error("output became valid without a pending result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.move && out_valid_r) |-> out_tready)
    else $error("pending result overwrote an untaken output");

endmodule

`default_nettype wire

// ===== rtl/opsm_datapath.sv =====
// Datapath: symbol buffer, pointers, pilot tracking and output register.
`default_nettype none

module opsm_datapath
  import opsm_pkg::*;
#(
  parameter int BUFFER_DEPTH = 1024
)(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  input  wire cfg_t                cfg,
  input  wire logic [SAMPLE_W-1:0] sym_real,
  input  wire logic [SAMPLE_W-1:0] sym_imag,
  output logic [SAMPLE_W-1:0]      carrier_real,
  output logic [SAMPLE_W-1:0]      carrier_imag,
  output logic [INDEX_W-1:0]       carrier_index,
  output logic                     end_of_symbol
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);

  // Symbol buffer
  logic [SAMPLE_W-1:0] mem_real [BUFFER_DEPTH];
  logic [SAMPLE_W-1:0] mem_imag [BUFFER_DEPTH];
  logic [SAMPLE_W-1:0] rd_real_r, rd_imag_r;

  logic [PW-1:0]          load_ptr_r, load_ptr_nxt;
  logic [PW-1:0]          fetch_ptr_r, fetch_ptr_nxt;
  logic [INDEX_W-1:0]     slot_r, slot_nxt;
  logic [PTOTAL_W-1:0]    placed_r, placed_nxt;
  logic [PILOT_POS_W-1:0] upcoming_r, upcoming_nxt;

  // Pending result
  src_t                pend_src_r;
  logic [SAMPLE_W-1:0] pend_pre_r, pend_pim_r;
  logic [INDEX_W-1:0]  pend_idx_r;
  logic                pend_last_r;

  logic                   first_slot, last_slot, in_band, is_pilot, is_data, fetch_ok;
  logic                   load_ok;
  logic [PILOT_POS_W-1:0] up_eff;
  logic [PTOTAL_W-1:0]    placed_eff;
  logic [11:0]            band_end, next_pos;
  logic [PILOT_POS_W-1:0] offset;
  src_t                   src;

  // Classify the current subcarrier
  always_comb begin
    first_slot = (slot_r == '0);
    last_slot  = (slot_r == LAST_INDEX);
    up_eff     = first_slot ? {1'b0, cfg.pilot_first} : upcoming_r;
    placed_eff = first_slot ? '0 : placed_r;
    band_end   = {2'b0, cfg.band_start} + {1'b0, cfg.band_width};
    in_band    = (slot_r >= cfg.band_start) && ({2'b0, slot_r} < band_end);
    offset     = {1'b0, slot_r} - {1'b0, cfg.band_start};
    is_pilot   = in_band && (placed_eff < cfg.pilot_total) && (offset == up_eff);
    fetch_ok   = (fetch_ptr_r < DEPTH_P);
    is_data    = in_band && !is_pilot && fetch_ok;
    next_pos   = {1'b0, up_eff} + {1'b0, cfg.pilot_spacing};
    load_ok    = (load_ptr_r < DEPTH_P);
    if (is_pilot) begin
      src = SRC_PILOT;
    end else if (is_data) begin
      src = SRC_DATA;
    end else begin
      src = SRC_ZERO;
    end
  end

  // Advance pointers and pilot tracking
  always_comb begin
    load_ptr_nxt  = load_ptr_r;
    fetch_ptr_nxt = fetch_ptr_r;
    slot_nxt      = slot_r;
    placed_nxt    = placed_r;
    upcoming_nxt  = upcoming_r;
    if (cmd.load && load_ok) begin
      load_ptr_nxt = load_ptr_r + PW'(1);
    end
    if (cmd.emit) begin
      if (last_slot) begin
        slot_nxt      = '0;
        load_ptr_nxt  = '0;
        fetch_ptr_nxt = '0;
        placed_nxt    = '0;
        upcoming_nxt  = {1'b0, cfg.pilot_first};
      end else begin
        slot_nxt = slot_r + INDEX_W'(1);
        if (is_pilot) begin
          placed_nxt   = placed_eff + PTOTAL_W'(1);
          upcoming_nxt = next_pos[11] ? PILOT_SAT : next_pos[PILOT_POS_W-1:0];
        end else begin
          placed_nxt   = placed_eff;
          upcoming_nxt = up_eff;
        end
        if (is_data) fetch_ptr_nxt = fetch_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r  <= '0;
      fetch_ptr_r <= '0;
      slot_r      <= '0;
      placed_r    <= '0;
      upcoming_r  <= {1'b0, RST_PILOT_FIRST};
    end else begin
      load_ptr_r  <= load_ptr_nxt;
      fetch_ptr_r <= fetch_ptr_nxt;
      slot_r      <= slot_nxt;
      placed_r    <= placed_nxt;
      upcoming_r  <= upcoming_nxt;
    end
  end

  // Buffer write on load, registered read on a data slot
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem_real[load_ptr_r[AW-1:0]] <= sym_real;
      mem_imag[load_ptr_r[AW-1:0]] <= sym_imag;
    end
    if (cmd.emit && is_data) begin
      rd_real_r <= mem_real[fetch_ptr_r[AW-1:0]];
      rd_imag_r <= mem_imag[fetch_ptr_r[AW-1:0]];
    end
  end

  // Capture the pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_src_r <= SRC_ZERO;
    end else if (cmd.emit) begin
      pend_src_r <= src;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_pre_r  <= cfg.pilot_real;
      pend_pim_r  <= cfg.pilot_imag;
      pend_idx_r  <= slot_r;
      pend_last_r <= last_slot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.move) begin
      unique case (pend_src_r)
        SRC_PILOT: begin
          carrier_real <= pend_pre_r;
          carrier_imag <= pend_pim_r;
        end
        SRC_DATA: begin
          carrier_real <= rd_real_r;
          carrier_imag <= rd_imag_r;
        end
        default: begin
          carrier_real <= '0;
          carrier_imag <= '0;
        end
      endcase
      carrier_index <= pend_idx_r;
      end_of_symbol <= pend_last_r;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_ofdm_pilot_subcarrier_mapper_core.sv =====
// Self-checking testbench for the OFDM pilot and subcarrier mapper core.
`timescale 1ns / 100ps

module tb_ofdm_pilot_subcarrier_mapper_core;
  import opsm_pkg::*;

  localparam int BUF_DEPTH   = 1024;
  localparam int IDLE_PCT    = 21;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_CAP  = 100;
  localparam int N_ROWS      = 18;

  // Index past the register file, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] re;
    logic [SAMPLE_W-1:0] im;
    logic [INDEX_W-1:0]  idx;
    logic                last;
  } carrier_t;

  typedef struct packed {
    req_t                kind;
    logic [SAMPLE_W-1:0] re;
    logic [SAMPLE_W-1:0] im;
    logic                typed;
    carrier_t            want;
  } row_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  ofdm_pilot_subcarrier_mapper_core #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register shadow
  logic [BSTART_W-1:0] band_start_r;
  logic [BWIDTH_W-1:0] band_width_r;
  logic [PTOTAL_W-1:0] pilot_total_r;
  logic [PSPACE_W-1:0] pilot_spacing_r;
  logic [PFIRST_W-1:0] pilot_first_r;
  logic [SAMPLE_W-1:0] pilot_real_r;
  logic [SAMPLE_W-1:0] pilot_imag_r;

  // Mapper state as the testbench sees it
  logic [SAMPLE_W-1:0]    buf_re     [BUF_DEPTH];
  logic [SAMPLE_W-1:0]    buf_im     [BUF_DEPTH];
  bit                     buf_filled [BUF_DEPTH];
  int                     wr_ptr;
  int                     rd_ptr;
  logic [INDEX_W-1:0]     slot_idx;
  logic [PTOTAL_W-1:0]    pilots_done;
  logic [PILOT_POS_W-1:0] pilot_pos;

  carrier_t pending_carriers [$];
  row_t     dir_rows [N_ROWS];

  int  err_count = 0;
  int  hold_left = 0;
  bit  calm      = 1'b0;
  int  quiet     = 0;
  int  n_loads   = 0;
  int  n_dropped = 0;
  int  n_pilot   = 0;
  int  n_data    = 0;
  int  n_zero    = 0;
  int  n_symbols = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out what the next emit request will produce
  function automatic src_t classify_slot();
    int unsigned idx, lo, hi, pos, done;
    idx  = slot_idx;
    lo   = band_start_r;
    hi   = lo + band_width_r;
    pos  = (slot_idx == '0) ? pilot_first_r : pilot_pos;
    done = (slot_idx == '0) ? 0 : pilots_done;
    if (idx < lo || idx >= hi) return SRC_ZERO;
    if (done < pilot_total_r && idx - lo == pos) return SRC_PILOT;
    return SRC_DATA;
  endfunction

  // Advance the mapper state by one request; returns 1 when a subcarrier results
  function automatic bit next_subcarrier(input req_t kind, input logic [SAMPLE_W-1:0] re,
                                         input logic [SAMPLE_W-1:0] im, output carrier_t c);
    src_t        src;
    int unsigned sum;
    c = '0;
    if (kind == REQ_LOAD) begin
      n_loads++;
      if (wr_ptr < BUF_DEPTH) begin
        buf_re[wr_ptr]     = re;
        buf_im[wr_ptr]     = im;
        buf_filled[wr_ptr] = 1'b1;
        wr_ptr++;
      end else begin
        n_dropped++;
      end
      return 1'b0;
    end
    src = classify_slot();
    if (slot_idx == '0) begin
      pilot_pos   = PILOT_POS_W'(pilot_first_r);
      pilots_done = '0;
    end
    case (src)
      SRC_PILOT: begin
        c.re = pilot_real_r;
        c.im = pilot_imag_r;
        pilots_done = pilots_done + 1'b1;
        sum = pilot_pos + pilot_spacing_r;
        pilot_pos = (sum > PILOT_SAT) ? PILOT_SAT : PILOT_POS_W'(sum);
        n_pilot++;
      end
      SRC_DATA: begin
        if (rd_ptr < BUF_DEPTH) begin
          c.re = buf_re[rd_ptr];
          c.im = buf_im[rd_ptr];
          rd_ptr++;
        end
        n_data++;
      end
      default: n_zero++;
    endcase
    c.idx  = slot_idx;
    c.last = (slot_idx == LAST_INDEX);
    // Wrap to the start of the next symbol
    if (c.last) begin
      slot_idx    = '0;
      wr_ptr      = 0;
      rd_ptr      = 0;
      pilots_done = '0;
      pilot_pos   = PILOT_POS_W'(pilot_first_r);
      n_symbols++;
    end else begin
      slot_idx = slot_idx + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_BAND_START:    band_start_r    = v[BSTART_W-1:0];
      REG_BAND_WIDTH:    band_width_r    = v[BWIDTH_W-1:0];
      REG_PILOT_TOTAL:   pilot_total_r   = v[PTOTAL_W-1:0];
      REG_PILOT_SPACING: pilot_spacing_r = v[PSPACE_W-1:0];
      REG_PILOT_FIRST:   pilot_first_r   = v[PFIRST_W-1:0];
      REG_PILOT_REAL:    pilot_real_r    = v[SAMPLE_W-1:0];
      REG_PILOT_IMAG:    pilot_imag_r    = v[SAMPLE_W-1:0];
      default: ;
    endcase
  endfunction

  // Bias samples towards the extremes now and then
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want,
                        input logic [INDEX_W-1:0] at);
    err_count++;
    if (err_count <= REPORT_CAP)
      $display("mismatch in %s at subcarrier %0d: got %h, expected %h", what, at, got, want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    shadow_write(idx, v);
  endtask

  task automatic program_regs(input logic [15:0] bs, bw, pt, ps, pf, pr, pi, input bit spare);
    write_reg(REG_BAND_START, bs);
    write_reg(REG_BAND_WIDTH, bw);
    write_reg(REG_PILOT_TOTAL, pt);
    write_reg(REG_PILOT_SPACING, ps);
    write_reg(REG_PILOT_FIRST, pf);
    write_reg(REG_PILOT_REAL, pr);
    write_reg(REG_PILOT_IMAG, pi);
    if (spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Offer one request, hold it until accepted, then record what it should produce
  task automatic send_request(input req_t kind, input logic [SAMPLE_W-1:0] re,
                              input logic [SAMPLE_W-1:0] im, input bit typed,
                              input carrier_t typed_want);
    carrier_t pred;
    bit       has_res;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {im, re};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has_res = next_subcarrier(kind, re, im, pred);
    if (has_res) pending_carriers.push_back(typed ? typed_want : pred);
  endtask

  // Stop offering and wait for every outstanding subcarrier
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_carriers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] bs, bw, pt, ps, pf, pr, pi, input bit spare,
                           input int n, input int load_pct, input bit steady,
                           input int squeeze_at);
    req_t kind;
    drain();
    program_regs(bs, bw, pt, ps, pf, pr, pi, spare);
    calm = steady;
    for (int i = 0; i < n; i++) begin
      if (i == squeeze_at) hold_left = HOLD_CYCLES;
      kind = ($urandom_range(0, 99) < load_pct) ? REQ_LOAD : REQ_EMIT;
      // Load ahead so a data slot never reads an entry that was never written
      if (kind == REQ_EMIT)
        while (classify_slot() == SRC_DATA && rd_ptr < BUF_DEPTH && !buf_filled[rd_ptr])
          send_request(REQ_LOAD, pick_sample(), pick_sample(), 1'b0, '0);
      send_request(kind, pick_sample(), pick_sample(), 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  // Result side: stall at random, or hold off for a long stretch on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare each subcarrier with the oldest outstanding one
  always @(posedge clk) begin
    carrier_t want;
    logic [INDEX_W-1:0] got_idx;
    got_idx = out_tdata[2*SAMPLE_W+INDEX_W-1:2*SAMPLE_W];
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_carriers.size() == 0) begin
        report("unrequested subcarrier", 32'(got_idx), '0, got_idx);
      end else begin
        want = pending_carriers.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== want.re)
          report("carrier_real", 32'(out_tdata[SAMPLE_W-1:0]), 32'(want.re), want.idx);
        if (out_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.im)
          report("carrier_imag", 32'(out_tdata[2*SAMPLE_W-1:SAMPLE_W]), 32'(want.im), want.idx);
        if (got_idx !== want.idx)
          report("carrier_index", 32'(got_idx), 32'(want.idx), want.idx);
        if (out_tlast !== want.last)
          report("end_of_symbol", 32'(out_tlast), 32'(want.last), want.idx);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // Shadow state after reset
    band_start_r    = RST_BAND_START;
    band_width_r    = RST_BAND_WIDTH;
    pilot_total_r   = RST_PILOT_TOTAL;
    pilot_spacing_r = RST_PILOT_SPACING;
    pilot_first_r   = RST_PILOT_FIRST;
    pilot_real_r    = RST_PILOT_REAL;
    pilot_imag_r    = RST_PILOT_IMAG;
    wr_ptr      = 0;
    rd_ptr      = 0;
    slot_idx    = '0;
    pilots_done = '0;
    pilot_pos   = PILOT_POS_W'(RST_PILOT_FIRST);
    foreach (buf_filled[i]) buf_filled[i] = 1'b0;

    // Directed rows: band from subcarrier 2, pilots at band offsets 1 and 4
    dir_rows = '{
      '{REQ_LOAD, 16'h7FFF, 16'h8000, 1'b0, '0},
      '{REQ_LOAD, 16'h8000, 16'h7FFF, 1'b0, '0},
      '{REQ_LOAD, 16'h0000, 16'hFFFF, 1'b0, '0},
      '{REQ_LOAD, 16'hFFFF, 16'h0000, 1'b0, '0},
      '{REQ_LOAD, 16'h5555, 16'hAAAA, 1'b0, '0},
      '{REQ_LOAD, 16'hAAAA, 16'h5555, 1'b0, '0},
      '{REQ_EMIT, 16'h1234, 16'h5678, 1'b1, '{16'h0000, 16'h0000, 10'd0, 1'b0}},
      '{REQ_EMIT, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, 16'h0000, 10'd1, 1'b0}},
      '{REQ_EMIT, 16'h0000, 16'h0000, 1'b1, '{16'h7FFF, 16'h8000, 10'd2, 1'b0}},
      '{REQ_EMIT, 16'h0000, 16'h0000, 1'b1, '{16'h8000, 16'h7FFF, 10'd3, 1'b0}},
      '{REQ_EMIT, 16'h0000, 16'h0000, 1'b1, '{16'h8000, 16'h7FFF, 10'd4, 1'b0}},
      '{REQ_LOAD, 16'h0F0F, 16'hF0F0, 1'b0, '0},
      '{REQ_EMIT, 16'h0000, 16'h0000, 1'b0, '0},
      '{REQ_EMIT, 16'h0000, 16'h0000, 1'b1, '{16'h8000, 16'h7FFF, 10'd6, 1'b0}},
      '{REQ_EMIT, 16'h0000, 16'h0000, 1'b0, '0},
      '{REQ_EMIT, 16'h0000, 16'h0000, 1'b0, '0},
      '{REQ_EMIT, 16'h0000, 16'h0000, 1'b0, '0},
      '{REQ_EMIT, 16'h0000, 16'h0000, 1'b0, '0}
    };

    // Synchronous reset, released at a falling clock edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: band running past the vector end, extreme pilot value
    program_regs(16'd2, 16'd1024, 16'd2, 16'd3, 16'd1, 16'h8000, 16'h7FFF, 1'b0);
    for (int r = 0; r < N_ROWS; r++)
      send_request(dir_rows[r].kind, dir_rows[r].re, dir_rows[r].im, dir_rows[r].typed,
                   dir_rows[r].want);

    // Random band and pilot layout, mixed traffic
    run_phase(16'($urandom_range(0, 400)), 16'($urandom_range(1, 700)),
              16'($urandom_range(0, 64)), 16'($urandom_range(1, 40)),
              16'($urandom_range(0, 20)), pick_sample(), pick_sample(), 1'b0,
              120, 45, 1'b0, -1);
    // Full band, no pilots, with a long hold-off on the result side
    run_phase(16'd0, 16'd1024, 16'd0, 16'd1, 16'd0, 16'h7FFF, 16'h8000, 1'b0,
              80, 0, 1'b0, 20);
    // Wide spacing: any pilot hit pushes the position to saturation; no idling
    run_phase(16'd5, 16'd1024, 16'd64, 16'd2047, 16'd3, 16'hFFFF, 16'h0001, 1'b0,
              50, 5, 1'b1, -1);
    // Zero spacing across a band that runs to the vector end
    run_phase(16'd0, 16'd1024, 16'd3, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 1'b0,
              50, 20, 1'b0, -1);
    // Empty band, top band start and pilot count, write to the spare index
    run_phase(16'd1023, 16'd0, 16'd127, 16'd0, 16'd1023, pick_sample(), pick_sample(), 1'b1,
              50, 40, 1'b0, -1);
    // Back to a random layout
    run_phase(16'($urandom_range(0, 1023)), 16'($urandom_range(1, 1024)),
              16'($urandom_range(0, 64)), 16'($urandom_range(1, 1024)),
              16'($urandom_range(0, 1023)), pick_sample(), pick_sample(), 1'b0,
              60, 35, 1'b0, -1);
    drain();

    $display("covered %0d loads (%0d dropped at a full buffer), %0d pilot, %0d data, %0d zero",
             n_loads, n_dropped, n_pilot, n_data, n_zero);
    $display("%0d symbols completed across 7 register settings, %0d mismatches",
             n_symbols, err_count);
    if (err_count == 0 && pending_carriers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
